>>> src/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared widths, register indexes, reset values and codes for the motor
// position PID controller.
// ----------------------------------------------------------------------------
package mpp_pkg;

  localparam int unsigned PULSES_PER_REV_DEF = 260;
  localparam int unsigned PWM_MAX_DEF        = 199;
  localparam int unsigned PWM_MIN_DEF        = 12;

  localparam int DEG_PER_REV = 360;
  localparam int ANGLE_LIMIT = 361;

  localparam int COUNT_W    = 16;
  localparam int MODE_W     = 3;
  localparam int TARGET_W   = 24;
  localparam int GAIN_W     = 32;
  localparam int POS_W      = 10;
  localparam int DIR_W      = 2;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [DIR_W-1:0]      dir_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_CW   = 2'd1;
  localparam dir_t DIR_CCW  = 2'd2;

  localparam cfg_idx_t CFG_MODE   = 3'd0;
  localparam cfg_idx_t CFG_TARGET = 3'd1;
  localparam cfg_idx_t CFG_PROP   = 3'd2;
  localparam cfg_idx_t CFG_INTEG  = 3'd3;
  localparam cfg_idx_t CFG_DERIV  = 3'd4;

  localparam logic [MODE_W-1:0]        MODE_RST   = 3'd4;
  localparam logic signed [TARGET_W-1:0] TARGET_RST = 24'sd0;
  localparam logic signed [GAIN_W-1:0] PROP_RST   = 32'sd32768;
  localparam logic signed [GAIN_W-1:0] INTEG_RST  = 32'sd1288;
  localparam logic signed [GAIN_W-1:0] DERIV_RST  = 32'sd25600;

endpackage

>>> src/mpp_if.sv
// ----------------------------------------------------------------------------
// mpp_if
// Valid/ready channels of the motor position PID controller: encoder sample,
// result and configuration write.
// ----------------------------------------------------------------------------
interface mpp_sample_if;
  import mpp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COUNT_W-1:0]  encoder_count;
  modport source (output valid, output encoder_count, input ready);
  modport sink   (input valid, input encoder_count, output ready);
endinterface

interface mpp_result_if;
  import mpp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  position_deg;
  dir_t                     direction;
  logic [DUTY_W-1:0]        pwm_duty;
  modport source (output valid, output position_deg, output direction, output pwm_duty,
                  input ready);
  modport sink   (input valid, input position_deg, input direction, input pwm_duty,
                  output ready);
endinterface

interface mpp_cfg_if;
  import mpp_pkg::*;
  logic                   valid;
  logic                   ready;
  cfg_idx_t               index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/motor_position_pid_top.sv
// ----------------------------------------------------------------------------
// motor_position_pid_top
// Position PID controller: encoder count in, angle, direction and PWM duty out.
// ----------------------------------------------------------------------------
// Channels: sample carries one encoder count per control tick; result returns
// one item per request (angle in whole degrees, direction, PWM duty); cfg
// writes the mode, target and gain registers (index 0..4, others dropped) and
// is always ready. Write cfg only while no request is in flight.
// Each request runs through one shared restoring divider (one quotient bit per
// cycle, 24 steps) and one shared 32x25 multiplier. When the angle exceeds
// +-361 degrees, the count is first wrapped (two more divider passes).
// sample.ready is low while a request is in flight, so a new request is taken
// only after the previous one has left its last step.
// The result sits in an output register: the next request is accepted while
// it waits. If the receiver stalls, a finished second request holds in its
// last step until the register frees up.
// Reset (rst, synchronous) restores the register defaults, clears the
// integral and last error, and drops any pending result.
// ----------------------------------------------------------------------------
module motor_position_pid_top #(
  parameter int unsigned PULSES_PER_REV = mpp_pkg::PULSES_PER_REV_DEF,
  parameter int unsigned PWM_MAX        = mpp_pkg::PWM_MAX_DEF,
  parameter int unsigned PWM_MIN        = mpp_pkg::PWM_MIN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  mpp_cfg_if.sink        cfg,
  mpp_sample_if.sink     sample,
  mpp_result_if.source   result
);
  import mpp_pkg::*;

  localparam int DIV_W   = $clog2((2**MODE_W - 1) * PULSES_PER_REV + 1);
  localparam int DVD_W   = $clog2((2**(COUNT_W-1)) * DEG_PER_REV + 1);
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int ERR_W   = TARGET_W;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PROD_W  = GAIN_W + DIFF_W;
  localparam int ACC_W   = 64;
  localparam int DRV_W   = 60;
  localparam int FRAC_W  = 16;
  localparam int DUTY_FW = DRV_W - FRAC_W;

  localparam logic [1:0] PASS_ANGLE = 2'd0;
  localparam logic [1:0] PASS_MOD   = 2'd1;
  localparam logic [1:0] PASS_WRAP  = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DIV  = 10'b0000000010,
    S_ERR  = 10'b0000000100,
    S_MP   = 10'b0000001000,
    S_MI   = 10'b0000010000,
    S_MD   = 10'b0000100000,
    S_SUM1 = 10'b0001000000,
    S_SUM2 = 10'b0010000000,
    S_ABS  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t                     state;
  logic [MODE_W-1:0]          mode;
  logic signed [TARGET_W-1:0] target;
  logic signed [GAIN_W-1:0]   kp;
  logic signed [GAIN_W-1:0]   ki;
  logic signed [GAIN_W-1:0]   kd;
  logic signed [ACC_W-1:0]    integral;
  logic signed [ERR_W-1:0]    last_err;
  logic signed [ERR_W-1:0]    err;
  logic                       neg;
  logic [COUNT_W-1:0]         cmag;
  logic [DIV_W-1:0]           divisor;
  logic [DVD_W-1:0]           dq;
  logic [DIV_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;
  logic [1:0]                 pass;
  logic signed [POS_W-1:0]    angle;
  logic signed [PROD_W-1:0]   prod;
  logic signed [DRV_W-1:0]    drive;
  logic [DUTY_FW-1:0]         duty_raw;
  dir_t                       dir;
  logic                       out_valid;
  logic signed [POS_W-1:0]    out_pos;
  dir_t                       out_dir;
  logic [DUTY_W-1:0]          out_duty;

  logic [MODE_W-1:0]          mode_eff;
  logic [COUNT_W-1:0]         in_mag;
  logic [DIV_W:0]             rem_sh;
  logic [DIV_W:0]             trial;
  logic                       fit;
  logic [POS_W-1:0]           q_pos;
  logic signed [ERR_W+1:0]    err_wide;
  logic signed [ERR_W-1:0]    err_sat;
  logic signed [GAIN_W-1:0]   mul_a;
  logic signed [DIFF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]    addend;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [ACC_W-1:0]    acc_sat;
  logic signed [DRV_W-1:0]    drv_mag;
  logic [DUTY_FW-1:0]         duty_cap;
  logic [DUTY_FW-1:0]         duty_fin;
  logic                       out_free;

  assign cfg.ready     = 1'b1;
  assign sample.ready  = (state == S_IDLE);
  assign result.valid  = out_valid;
  assign result.position_deg = out_pos;
  assign result.direction    = out_dir;
  assign result.pwm_duty     = out_duty;
  assign out_free = !out_valid || result.ready;

  // divider step and input conditioning
  assign mode_eff = (mode == '0) ? MODE_W'(1) : mode;
  assign in_mag   = sample.encoder_count[COUNT_W-1] ? (~sample.encoder_count + 1'b1)
                                                    : sample.encoder_count;
  assign rem_sh   = {rem, dq[DVD_W-1]};
  assign trial    = rem_sh - {1'b0, divisor};
  assign fit      = !trial[DIV_W];
  assign q_pos    = dq[POS_W-1:0];

  // error with saturation
  assign err_wide = (ERR_W+2)'(target) - ((ERR_W+2)'(angle) <<< 8);
  always_comb begin
    if (err_wide[ERR_W+1:ERR_W-1] == 3'b000 || err_wide[ERR_W+1:ERR_W-1] == 3'b111) begin
      err_sat = err_wide[ERR_W-1:0];
    end else if (err_wide[ERR_W+1]) begin
      err_sat = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      err_sat = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MI: begin
        mul_a = ki;
        mul_b = DIFF_W'(err);
      end
      S_MD: begin
        mul_a = kd;
        mul_b = DIFF_W'(err) - DIFF_W'(last_err);
      end
      default: begin
        mul_a = kp;
        mul_b = DIFF_W'(err);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // saturating integral update
  assign addend  = ACC_W'(prod);
  assign acc_sum = integral + addend;
  always_comb begin
    if ((integral[ACC_W-1] == addend[ACC_W-1]) && (acc_sum[ACC_W-1] != integral[ACC_W-1])) begin
      acc_sat = integral[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum;
    end
  end

  // duty shaping
  assign drv_mag  = drive[DRV_W-1] ? -drive : drive;
  always_comb begin
    duty_cap = (duty_raw > DUTY_FW'(PWM_MAX)) ? DUTY_FW'(PWM_MAX) : duty_raw;
    duty_fin = duty_cap;
    if (duty_cap < DUTY_FW'(PWM_MIN) && err != '0) begin
      duty_fin = DUTY_FW'(PWM_MIN);
    end
    if (dir == DIR_STOP) begin
      duty_fin = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_RST;
      target <= TARGET_RST;
      kp     <= PROP_RST;
      ki     <= INTEG_RST;
      kd     <= DERIV_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MODE:   mode   <= cfg.data[MODE_W-1:0];
        CFG_TARGET: target <= cfg.data[TARGET_W-1:0];
        CFG_PROP:   kp     <= cfg.data[GAIN_W-1:0];
        CFG_INTEG:  ki     <= cfg.data[GAIN_W-1:0];
        CFG_DERIV:  kd     <= cfg.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      integral  <= '0;
      last_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            neg     <= sample.encoder_count[COUNT_W-1];
            cmag    <= in_mag;
            divisor <= DIV_W'(32'(mode_eff) * PULSES_PER_REV);
            dq      <= DVD_W'(32'(in_mag) * DEG_PER_REV);
            rem     <= '0;
            cnt     <= CNT_W'(DVD_W);
            pass    <= PASS_ANGLE;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt != '0) begin
            rem <= fit ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            dq  <= {dq[DVD_W-2:0], fit};
            cnt <= cnt - 1'b1;
          end else begin
            priority if (pass == PASS_ANGLE && dq > DVD_W'(ANGLE_LIMIT)) begin
              dq   <= DVD_W'(cmag);
              rem  <= '0;
              cnt  <= CNT_W'(DVD_W);
              pass <= PASS_MOD;
            end else if (pass == PASS_MOD) begin
              dq   <= DVD_W'(32'(rem) * DEG_PER_REV);
              rem  <= '0;
              cnt  <= CNT_W'(DVD_W);
              pass <= PASS_WRAP;
            end else begin
              angle <= neg ? -$signed(q_pos) : $signed(q_pos);
              state <= S_ERR;
            end
          end
        end
        S_ERR: begin
          err   <= err_sat;
          state <= S_MP;
        end
        S_MP: begin
          prod  <= mul_p;
          state <= S_MI;
        end
        S_MI: begin
          drive <= DRV_W'(prod >>> 8);
          prod  <= mul_p;
          state <= S_MD;
        end
        S_MD: begin
          integral <= acc_sat;
          prod     <= mul_p;
          last_err <= err;
          state    <= S_SUM1;
        end
        S_SUM1: begin
          drive <= drive + DRV_W'(integral >>> 24);
          state <= S_SUM2;
        end
        S_SUM2: begin
          drive <= drive + DRV_W'(prod);
          state <= S_ABS;
        end
        S_ABS: begin
          priority if (drive[DRV_W-1]) begin
            dir <= DIR_CCW;
          end else if (drive != '0) begin
            dir <= DIR_CW;
          end else begin
            dir <= DIR_STOP;
          end
          duty_raw <= drv_mag[DRV_W-1:FRAC_W];
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_pos   <= angle;
            out_dir   <= dir;
            out_duty  <= duty_fin[DUTY_W-1:0];
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> bench/motor_position_pid_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_position_pid_top_test
// Self-checking bench for the position PID controller. Encoder counts go in on
// the sample channel and a local model of the angle, error, PID drive and duty
// predicts each result. Register settings change only while the block is idle.
// Both sides of the stream idle at random, and the result side also holds off
// for a long stretch.
// ----------------------------------------------------------------------------
module motor_position_pid_top_test;
  import mpp_pkg::*;

  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     TAIL_CYCLES = 100;
  localparam int     HOLD_CYCLES = 400;
  localparam int     IDLE_PCT    = 20;
  localparam int     PULSES      = PULSES_PER_REV_DEF;
  localparam longint ERR_HI      = (64'sd1 <<< (TARGET_W - 1)) - 1;
  localparam longint ERR_LO      = -(64'sd1 <<< (TARGET_W - 1));

  localparam cfg_idx_t CFG_UNUSED_FIRST = 3'd5;
  localparam cfg_idx_t CFG_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic signed [POS_W-1:0] position_deg;
    dir_t                    direction;
    logic [DUTY_W-1:0]       pwm_duty;
  } tick_result_t;

  logic clk;
  logic rst;

  mpp_cfg_if    cfg_ch ();
  mpp_sample_if sample_ch ();
  mpp_result_if result_ch ();

  motor_position_pid_top DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .result (result_ch)
  );

  logic [MODE_W-1:0]          mode_r;
  logic signed [TARGET_W-1:0] target_r;
  logic signed [GAIN_W-1:0]   kp_r;
  logic signed [GAIN_W-1:0]   ki_r;
  logic signed [GAIN_W-1:0]   kd_r;
  longint                     integ_acc;
  longint                     prev_err;

  tick_result_t expected_ticks[$];
  int           failures;
  int           cycle_count;
  int           hold_left;
  bit           hold_off_req;
  bit           idle_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_model();
    mode_r    = MODE_RST;
    target_r  = TARGET_RST;
    kp_r      = PROP_RST;
    ki_r      = INTEG_RST;
    kd_r      = DERIV_RST;
    integ_acc = 0;
    prev_err  = 0;
  endfunction

  function automatic void store_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_MODE:   mode_r   = value[MODE_W-1:0];
      CFG_TARGET: target_r = value[TARGET_W-1:0];
      CFG_PROP:   kp_r     = value;
      CFG_INTEG:  ki_r     = value;
      CFG_DERIV:  kd_r     = value;
      default: ;
    endcase
  endfunction

  function automatic tick_result_t predict_tick(input logic signed [COUNT_W-1:0] count);
    int                span;
    int                cnt;
    int                ang;
    longint            err;
    longint            drive;
    longint            mag;
    longint            duty;
    logic signed [64:0] acc;
    tick_result_t      r;
    span = ((mode_r == 0) ? 1 : int'(mode_r)) * PULSES;
    cnt  = count;
    ang  = (cnt * DEG_PER_REV) / span;
    if (ang > ANGLE_LIMIT || ang < -ANGLE_LIMIT) begin
      cnt = cnt % span;
      ang = (cnt * DEG_PER_REV) / span;
    end
    err = longint'(target_r) - longint'(ang) * 256;
    if (err > ERR_HI) err = ERR_HI;
    if (err < ERR_LO) err = ERR_LO;
    acc = 65'(integ_acc) + 65'(longint'(ki_r) * err);
    if (acc[64] != acc[63]) begin
      integ_acc = acc[64] ? longint'(64'h8000_0000_0000_0000)
                          : longint'(64'h7FFF_FFFF_FFFF_FFFF);
    end else begin
      integ_acc = acc[63:0];
    end
    drive = ((longint'(kp_r) * err) >>> 8) + (integ_acc >>> 24)
          + longint'(kd_r) * (err - prev_err);
    prev_err = err;
    if (drive < 0) begin
      r.direction = DIR_CCW;
      mag = -drive;
    end else if (drive > 0) begin
      r.direction = DIR_CW;
      mag = drive;
    end else begin
      r.direction = DIR_STOP;
      mag = 0;
    end
    duty = mag >>> 16;
    if (duty > longint'(PWM_MAX_DEF)) duty = PWM_MAX_DEF;
    if (duty < longint'(PWM_MIN_DEF) && err != 0) duty = PWM_MIN_DEF;
    if (r.direction == DIR_STOP) duty = 0;
    r.position_deg = ang[POS_W-1:0];
    r.pwm_duty     = duty[DUTY_W-1:0];
    return r;
  endfunction

  function automatic logic signed [COUNT_W-1:0] random_count();
    if ($urandom_range(3) == 0) return COUNT_W'($urandom);
    return COUNT_W'(int'($urandom_range(2400)) - 1200);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    store_reg(idx, value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] mode, input logic [CFG_DATA_W-1:0] target,
                           input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                           input logic [CFG_DATA_W-1:0] kd);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_TARGET, target);
    write_reg(CFG_PROP, kp);
    write_reg(CFG_INTEG, ki);
    write_reg(CFG_DERIV, kd);
  endtask

  task automatic send_count(input logic signed [COUNT_W-1:0] count);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 60);
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.encoder_count <= count;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    expected_ticks.push_back(predict_tick(count));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_count(16'sd0);
    send_count(16'sh7FFF);
    send_count(16'sh8000);
    send_count(16'sd1045);
    send_count(-16'sd1046);
    wait_idle();
  endtask

  task automatic test_encoder_modes();
    int span;
    int edge_cnt;
    for (int m = 0; m < 8; m++) begin
      write_reg(CFG_MODE, 32'(m));
      span     = ((m == 0) ? 1 : m) * PULSES;
      edge_cnt = (362 * span - 1) / 360;
      send_count((m % 2) ? COUNT_W'(edge_cnt + 1) : COUNT_W'(-edge_cnt));
      wait_idle();
    end
  endtask

  // cancel the held integral with the P term so the drive lands on -1, 0, +1
  task automatic test_zero_drive();
    longint held;
    write_reg(CFG_INTEG, 32'd0);
    write_reg(CFG_DERIV, 32'd0);
    write_reg(CFG_MODE, 32'd4);
    write_reg(CFG_TARGET, 32'd256);
    held = integ_acc >>> 24;
    for (int delta = -1; delta <= 1; delta++) begin
      write_reg(CFG_PROP, 32'(-held + delta));
      send_count(16'sd0);
      wait_idle();
    end
  endtask

  task automatic test_unused_index();
    for (int i = CFG_UNUSED_FIRST; i <= CFG_UNUSED_LAST; i++) write_reg(cfg_idx_t'(i), $urandom);
    send_count(16'sd1045);
    wait_idle();
  endtask

  task automatic test_error_saturation();
    write_all(32'd4, 32'h007F_FFFF, PROP_RST, INTEG_RST, DERIV_RST);
    send_count(-16'sd1045);
    wait_idle();
    write_reg(CFG_TARGET, 32'h0080_0000);
    send_count(16'sd1045);
    wait_idle();
  endtask

  task automatic test_random_gains();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: write_all(32'd7, 32'h007F_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        1: write_all(32'd1, 32'hFF80_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        2: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
        default: begin
          write_all(($urandom_range(3) == 0) ? $urandom_range(7) : (($urandom_range(1) == 0) ? 1 : 4),
                    32'($urandom_range(2 * 92160)) - 92160,
                    32'($urandom_range(1 << 17)) - (1 << 16),
                    32'($urandom_range(1 << 13)) - (1 << 12),
                    32'($urandom_range(1 << 11)) - (1 << 10));
        end
      endcase
      repeat (15) send_count(random_count());
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    write_all(32'd4, 32'($urandom_range(2 * 92160)) - 92160, PROP_RST, INTEG_RST, DERIV_RST);
    hold_off_req = 1'b1;
    repeat (8) send_count(random_count());
    wait_idle();
  endtask

  // drive the integral into its positive limit, then pull it back off
  task automatic test_integral_saturation();
    write_all(32'd4, 32'h007F_FFFF, 32'($urandom_range(1 << 17)) - (1 << 16),
              32'h7FFF_FFFF, 32'($urandom_range(1 << 11)) - (1 << 10));
    idle_on = 1'b0;
    for (int n = 0; n < 560; n++) begin
      if (n == 200) idle_on = 1'b1;
      send_count(random_count());
    end
    wait_idle();
    write_reg(CFG_INTEG, 32'h8000_0000);
    repeat (20) send_count(random_count());
    wait_idle();
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (expected_ticks.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = expected_ticks.pop_front();
        if (result_ch.position_deg !== want.position_deg) begin
          $error("position_deg: expected %0d, got %0d", want.position_deg,
                 result_ch.position_deg);
          failures++;
        end
        if (result_ch.direction !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, result_ch.direction);
          failures++;
        end
        if (result_ch.pwm_duty !== want.pwm_duty) begin
          $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, result_ch.pwm_duty);
          failures++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst                     = 1'b1;
    sample_ch.valid         = 1'b0;
    sample_ch.encoder_count = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = CFG_MODE;
    cfg_ch.data             = '0;
    failures                = 0;
    hold_left               = 0;
    hold_off_req            = 1'b0;
    idle_on                 = 1'b1;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_encoder_modes();
    test_zero_drive();
    test_unused_index();
    test_error_saturation();
    test_random_gains();
    test_output_backpressure();
    test_integral_saturation();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mpp_pkg.sv
src/mpp_if.sv
src/motor_position_pid_top.sv
bench/motor_position_pid_top_test.sv
